@@ hdl/bdc_pkg.sv @@
// shared constants and register codes for the blended distance cost block
// no dependencies
package bdc_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF     = 14;
    localparam int SQRT_FRAC_BITS_DEF = 8;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // fixed field widths
    localparam int COST_W = 19;
    localparam int SLOT_W = 8;

    // configuration port index width
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_X     = 3'd0,
        REG_TRACK_Y     = 3'd1,
        REG_PREDICTED_X = 3'd2,
        REG_PREDICTED_Y = 3'd3,
        REG_MEASURED_GAIN = 3'd4
    } cfg_reg_t;

endpackage

@@ hdl/blended_distance_cost.sv @@
// blended distance cost: top level, full datapath in one module
// depends on bdc_pkg for parameter defaults, field widths and register codes
// depth: set by the square root, which produces one root bit per stage;
//   ROOT_W is half the even-rounded radicand width (2*COORD_BITS+1+2*SQRT_FRAC_BITS)
// throughput: one item per cycle while m_tready does not stall the output
// reset: aresetn, synchronous active low, empties every stage and sets the coordinates
//   to zero and measured_gain to one half; no clearing pass is needed
module blended_distance_cost #(
    parameter int COORD_BITS     = bdc_pkg::COORD_BITS_DEF,
    parameter int SQRT_FRAC_BITS = bdc_pkg::SQRT_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS = bdc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // configuration write port
    input  logic                                   cfg_we,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]          cfg_addr,
    input  logic [((COORD_BITS > GAIN_FRAC_BITS+1) ? COORD_BITS
                   : GAIN_FRAC_BITS+1)-1:0]        cfg_wdata,

    // candidate stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // cand_x, cand_y, slot, zero pad
    input  logic [((2*COORD_BITS+bdc_pkg::SLOT_W+7)/8)*8-1:0] s_tdata,

    // cost stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cost, slot_out, zero pad
    output logic [((bdc_pkg::COST_W+bdc_pkg::SLOT_W+7)/8)*8-1:0] m_tdata
);
    import bdc_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int SF      = SQRT_FRAC_BITS;
    localparam int GF      = GAIN_FRAC_BITS;
    localparam int GAIN_W  = GF + 1;
    localparam int G10_W   = GAIN_W + 4;          // gain times ten
    localparam int SQ_W    = 2*CB + 1;            // dx*dx + dy*dy
    localparam int RAD_W   = SQ_W + 2*SF;
    localparam int RAD_E   = RAD_W + (RAD_W % 2); // even, two bits consumed per stage
    localparam int ROOT_W  = RAD_E / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int PROD_W  = G10_W + ROOT_W;
    localparam int TERM_W  = PROD_W - GF - SF;
    localparam int OUT_W   = ((COST_W+SLOT_W+7)/8)*8;

    // stage map: input, difference, square, radicand, ROOT_W root stages,
    // product, output register
    localparam int ST_SQRT0 = 3;
    localparam int ST_PROD  = ROOT_W + 4;
    localparam int ST_OUT   = ROOT_W + 5;
    localparam int NS       = ROOT_W + 6;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GF;

    // absolute difference of two signed coordinates, fits CB bits unsigned
    function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] d;
        logic [CB:0] m;
        d = {a[CB-1], a} - {b[CB-1], b};
        m = d[CB] ? (~d + (CB+1)'(1)) : d;
        return m[CB-1:0];
    endfunction

    // configuration registers
    logic [CB-1:0]     track_x_reg, track_y_reg, pred_x_reg, pred_y_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_x_reg <= '0;
            track_y_reg <= '0;
            pred_x_reg  <= '0;
            pred_y_reg  <= '0;
            gain_reg    <= GAIN_ONE >> 1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TRACK_X:       track_x_reg <= cfg_wdata[CB-1:0];
                REG_TRACK_Y:       track_y_reg <= cfg_wdata[CB-1:0];
                REG_PREDICTED_X:   pred_x_reg  <= cfg_wdata[CB-1:0];
                REG_PREDICTED_Y:   pred_y_reg  <= cfg_wdata[CB-1:0];
                REG_MEASURED_GAIN: gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // weights, saturated above one and premultiplied by ten; config changes are for the
    // user to make only while idle (not enforced), so these settle before the product stage
    logic [GAIN_W-1:0] g_meas, g_pred;
    logic [G10_W-1:0]  g10_meas_reg, g10_pred_reg;

    assign g_meas = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign g_pred = GAIN_ONE - g_meas;

    always_ff @(posedge aclk) begin
        g10_meas_reg <= G10_W'({g_meas, 3'b000}) + G10_W'({g_meas, 1'b0});
        g10_pred_reg <= G10_W'({g_pred, 3'b000}) + G10_W'({g_pred, 1'b0});
    end

    // per-stage valid bits and load enables; a stage loads when it is empty
    // or its content moves on, so bubbles close up and a stall holds everything
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] take;

    always_comb begin
        take[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS-2; i >= 0; i--) begin
            take[i] = !vld_reg[i] || take[i+1];
        end
    end

    assign s_tready = take[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (take[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (take[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0: capture the candidate on transfer
    logic [CB-1:0]     cx_reg, cy_reg;
    logic [SLOT_W-1:0] slot0_reg;

    always_ff @(posedge aclk) begin
        if (take[0]) begin
            cx_reg    <= s_tdata[CB-1:0];
            cy_reg    <= s_tdata[2*CB-1:CB];
            slot0_reg <= s_tdata[2*CB+SLOT_W-1:2*CB];
        end
    end

    // stage 1: absolute coordinate differences to both track points
    logic [CB-1:0]     adx1_reg, ady1_reg, adx2_reg, ady2_reg;
    logic [SLOT_W-1:0] slot1_reg;

    always_ff @(posedge aclk) begin
        if (take[1]) begin
            adx1_reg  <= abs_diff(track_x_reg, cx_reg);
            ady1_reg  <= abs_diff(track_y_reg, cy_reg);
            adx2_reg  <= abs_diff(pred_x_reg, cx_reg);
            ady2_reg  <= abs_diff(pred_y_reg, cy_reg);
            slot1_reg <= slot0_reg;
        end
    end

    // stage 2: squares
    logic [2*CB-1:0]   sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic [SLOT_W-1:0] slot2_reg;

    always_ff @(posedge aclk) begin
        if (take[2]) begin
            sx1_reg   <= (2*CB)'(adx1_reg) * (2*CB)'(adx1_reg);
            sy1_reg   <= (2*CB)'(ady1_reg) * (2*CB)'(ady1_reg);
            sx2_reg   <= (2*CB)'(adx2_reg) * (2*CB)'(adx2_reg);
            sy2_reg   <= (2*CB)'(ady2_reg) * (2*CB)'(ady2_reg);
            slot2_reg <= slot1_reg;
        end
    end

    // root pipeline state: index 0 is the radicand stage, index k holds
    // k root bits; rad shifts left two bits per stage
    logic [RAD_E-1:0]  rad1_reg  [0:ROOT_W];
    logic [RAD_E-1:0]  rad2_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem1_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem2_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root1_reg [0:ROOT_W];
    logic [ROOT_W-1:0] root2_reg [0:ROOT_W];
    logic [SLOT_W-1:0] slots_reg [0:ROOT_W];

    // stage 3: radicand = (dx*dx + dy*dy) scaled up by 2*SF fraction bits
    always_ff @(posedge aclk) begin
        if (take[ST_SQRT0]) begin
            rad1_reg[0]  <= (RAD_E'(sx1_reg) + RAD_E'(sy1_reg)) << (2*SF);
            rad2_reg[0]  <= (RAD_E'(sx2_reg) + RAD_E'(sy2_reg)) << (2*SF);
            rem1_reg[0]  <= '0;
            rem2_reg[0]  <= '0;
            root1_reg[0] <= '0;
            root2_reg[0] <= '0;
            slots_reg[0] <= slot2_reg;
        end
    end

    // one restoring square root step per stage, both distances side by side
    for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
        logic [REM_W-1:0]  rs1, rs2, tr1, tr2;
        logic [REM_W-1:0]  rem1_next, rem2_next;
        logic [ROOT_W-1:0] root1_next, root2_next;

        always_comb begin
            rs1 = {rem1_reg[k-1][REM_W-3:0], rad1_reg[k-1][RAD_E-1:RAD_E-2]};
            rs2 = {rem2_reg[k-1][REM_W-3:0], rad2_reg[k-1][RAD_E-1:RAD_E-2]};
            tr1 = REM_W'({root1_reg[k-1], 2'b01});
            tr2 = REM_W'({root2_reg[k-1], 2'b01});
            if (rs1 >= tr1) begin
                rem1_next  = rs1 - tr1;
                root1_next = {root1_reg[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                rem1_next  = rs1;
                root1_next = {root1_reg[k-1][ROOT_W-2:0], 1'b0};
            end
            if (rs2 >= tr2) begin
                rem2_next  = rs2 - tr2;
                root2_next = {root2_reg[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                rem2_next  = rs2;
                root2_next = {root2_reg[k-1][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (take[ST_SQRT0+k]) begin
                rad1_reg[k]  <= rad1_reg[k-1] << 2;
                rad2_reg[k]  <= rad2_reg[k-1] << 2;
                rem1_reg[k]  <= rem1_next;
                rem2_reg[k]  <= rem2_next;
                root1_reg[k] <= root1_next;
                root2_reg[k] <= root2_next;
                slots_reg[k] <= slots_reg[k-1];
            end
        end
    end

    // product stage: weight times ten times norm
    logic [PROD_W-1:0] prod1_reg, prod2_reg;
    logic [SLOT_W-1:0] slotp_reg;

    always_ff @(posedge aclk) begin
        if (take[ST_PROD]) begin
            prod1_reg <= PROD_W'(g10_meas_reg) * PROD_W'(root1_reg[ROOT_W]);
            prod2_reg <= PROD_W'(g10_pred_reg) * PROD_W'(root2_reg[ROOT_W]);
            slotp_reg <= slots_reg[ROOT_W];
        end
    end

    // output register: each term truncated on its own, then summed modulo 2^COST_W
    logic [TERM_W-1:0] term1, term2;
    logic [COST_W-1:0] cost_reg;
    logic [SLOT_W-1:0] slot_out_reg;

    assign term1 = prod1_reg[PROD_W-1:GF+SF];
    assign term2 = prod2_reg[PROD_W-1:GF+SF];

    always_ff @(posedge aclk) begin
        if (take[ST_OUT]) begin
            cost_reg     <= COST_W'(term1) + COST_W'(term2);
            slot_out_reg <= slotp_reg;
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = OUT_W'({slot_out_reg, cost_reg});

endmodule
